// File: rtl/nfs_pkg.sv
// Shared types and constants for the NOR flash store model.
// Field widths, function and status codes, and the sequencer state type.
// No dependencies.
package nfs_pkg;

  localparam int ADDR_W   = 24;
  localparam int LEN_W    = 25;
  localparam int CMP_W    = 26;  // holds address + length without overflow

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  localparam logic [1:0] FN_READ        = 2'd0;
  localparam logic [1:0] FN_PROGRAM     = 2'd1;
  localparam logic [1:0] FN_ERASE_SEC   = 2'd2;
  localparam logic [1:0] FN_ERASE_RANGE = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_READY  = 3'd1;
  localparam logic [2:0] ST_BOUNDS     = 3'd2;
  localparam logic [2:0] ST_SET_BIT    = 3'd3;
  localparam logic [2:0] ST_RUN_FAILED = 3'd4;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_CHECK  = 10'b0000000100,
    S_DATA   = 10'b0000001000,
    S_DIV    = 10'b0000010000,
    S_BASE   = 10'b0000100000,
    S_SETUP  = 10'b0001000000,
    S_SECCHK = 10'b0010000000,
    S_ERASE  = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

endpackage

// File: rtl/nor_flash_store_model.sv
// Top level of the NOR flash store model: sequencer, byte store and run state.
// Depends on nfs_pkg.
//
// Emulated NOR flash of CAPACITY_BYTES bytes with byte read, byte program (bits
// only clear), sector erase and range erase. After reset the block sweeps the
// whole store to 0xFF, one byte per cycle, with in_stall high throughout; the
// cfg port is taken during that sweep. One word is handled at a time through a
// byte store with one write port and a registered read port: a read or program
// that reaches the store steps through accept, check plus store read,
// data/write and result, and a rejected or not-ready word skips the data/write
// step. Erases first find the sector base with a reciprocal multiply, a base
// multiply and a one-step fix-up, then write one byte per cycle, covering each
// sector of the erase in turn. A new word is accepted while the previous result
// still waits at the output; the next result then waits until that one has been
// taken.
module nor_flash_store_model #(
  parameter int CAPACITY_BYTES = 65536,
  parameter int SECTOR_BYTES   = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic                        in_run_start,
  input  logic [nfs_pkg::ADDR_W-1:0]  in_address,
  input  logic [nfs_pkg::LEN_W-1:0]   in_run_length,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [2:0]                  out_status,
  output logic [7:0]                  out_read_data
);

  localparam int AW     = $clog2(CAPACITY_BYTES);
  localparam int REM_W  = $clog2(SECTOR_BYTES);
  // quotient and reciprocal width: 2^ADDR_W / SECTOR_BYTES stays below 2^QW
  localparam int QW     = nfs_pkg::ADDR_W - REM_W + 1;
  localparam int PROD_W = nfs_pkg::ADDR_W + QW;
  localparam logic [nfs_pkg::CMP_W-1:0] CAP_C = nfs_pkg::CMP_W'(CAPACITY_BYTES);
  localparam logic [nfs_pkg::CMP_W-1:0] SEC_C = nfs_pkg::CMP_W'(SECTOR_BYTES);
  localparam logic [AW-1:0]    CAP_LAST = AW'(CAPACITY_BYTES - 1);
  localparam logic [REM_W-1:0] SEC_LAST = REM_W'(SECTOR_BYTES - 1);
  localparam logic [QW-1:0]    RCP_C    = QW'((1 << nfs_pkg::ADDR_W) / SECTOR_BYTES);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  nfs_pkg::state_t state_r, state_nxt;

  logic                         ready_r;
  logic [1:0]                   func_r, func_nxt;
  logic                         start_r, start_nxt;
  logic [nfs_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [nfs_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [7:0]                   data_r, data_nxt;

  logic [nfs_pkg::ADDR_W-1:0]   run_cur_r, run_cur_nxt;
  logic [nfs_pkg::LEN_W-1:0]    run_rem_r, run_rem_nxt;
  logic                         run_failed_r, run_failed_nxt;

  logic [nfs_pkg::ADDR_W-1:0]   acc_addr_r, acc_addr_nxt;
  logic [2:0]                   res_status_r, res_status_nxt;
  logic [7:0]                   res_rd_r, res_rd_nxt;

  logic [QW-1:0]                q_r, q_nxt;
  logic [nfs_pkg::CMP_W-1:0]    cur_r, cur_nxt;
  logic [nfs_pkg::CMP_W-1:0]    end_r, end_nxt;
  logic [AW-1:0]                waddr_r, waddr_nxt;
  logic [REM_W-1:0]             off_r, off_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [2:0]                   out_status_r, out_status_nxt;
  logic [7:0]                   out_rd_r, out_rd_nxt;

  // store port
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [7:0]                   mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [7:0]                   mem_q_r;
  logic [7:0]                   mem [CAPACITY_BYTES];

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic [nfs_pkg::CMP_W-1:0]    addr_w, len_w, range_end;
  logic                         range_ok;
  logic [nfs_pkg::ADDR_W-1:0]   idx;
  logic [nfs_pkg::LEN_W-1:0]    base_rem;
  logic [PROD_W-1:0]            q_prod;
  logic [nfs_pkg::CMP_W-1:0]    base_est;
  logic [nfs_pkg::CMP_W-1:0]    sec_off;
  logic                         sec_fits;
  logic                         out_free;

  assign addr_w    = {2'b00, addr_r};
  assign len_w     = {1'b0, len_r};
  assign range_end = addr_w + len_w;
  assign range_ok  = (len_r == '0) || ((addr_w < CAP_C) && (range_end <= CAP_C));
  assign idx       = start_r ? addr_r : run_cur_r;
  assign base_rem  = start_r ? len_r : run_rem_r;
  assign q_prod    = {{QW{1'b0}}, addr_r} * {{nfs_pkg::ADDR_W{1'b0}}, RCP_C};
  assign base_est  = {{(nfs_pkg::CMP_W - QW){1'b0}}, q_r} * SEC_C;
  assign sec_off   = addr_w - cur_r;
  assign sec_fits  = (cur_r < CAP_C) && ((cur_r + SEC_C) <= CAP_C);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall      = (state_r != nfs_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_ok        = (out_status_r == nfs_pkg::ST_OK);
  assign out_read_data = out_rd_r;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    start_nxt      = start_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    data_nxt       = data_r;
    run_cur_nxt    = run_cur_r;
    run_rem_nxt    = run_rem_r;
    run_failed_nxt = run_failed_r;
    acc_addr_nxt   = acc_addr_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    q_nxt          = q_r;
    cur_nxt        = cur_r;
    end_nxt        = end_r;
    waddr_nxt      = waddr_r;
    off_nxt        = off_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    mem_we         = 1'b0;
    mem_waddr      = waddr_r;
    mem_wdata      = nfs_pkg::FILL_BYTE;
    mem_raddr      = idx[AW-1:0];

    case (state_r)
      nfs_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        waddr_nxt = waddr_r + 1'b1;
        if (waddr_r == CAP_LAST) begin
          state_nxt = nfs_pkg::S_IDLE;
        end
      end

      nfs_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          start_nxt = in_run_start;
          addr_nxt  = in_address;
          len_nxt   = in_run_length;
          data_nxt  = in_data_byte;
          state_nxt = nfs_pkg::S_CHECK;
        end
      end

      nfs_pkg::S_CHECK: begin
        res_status_nxt = nfs_pkg::ST_OK;
        res_rd_nxt     = 8'h00;
        if (!ready_r) begin
          res_status_nxt = nfs_pkg::ST_NOT_READY;
          state_nxt      = nfs_pkg::S_FIN;
        end else if (func_r == nfs_pkg::FN_ERASE_SEC) begin
          state_nxt = nfs_pkg::S_DIV;
        end else if (func_r == nfs_pkg::FN_ERASE_RANGE) begin
          if (!range_ok) begin
            res_status_nxt = nfs_pkg::ST_BOUNDS;
            state_nxt      = nfs_pkg::S_FIN;
          end else if (len_r == '0) begin
            state_nxt = nfs_pkg::S_FIN;
          end else begin
            state_nxt = nfs_pkg::S_DIV;
          end
        end else begin
          state_nxt    = nfs_pkg::S_FIN;
          acc_addr_nxt = idx;
          if (start_r && !range_ok) begin
            run_rem_nxt    = '0;
            run_failed_nxt = 1'b0;
            res_status_nxt = nfs_pkg::ST_BOUNDS;
          end else if (start_r && (len_r == '0)) begin
            run_rem_nxt    = '0;
            run_failed_nxt = 1'b0;
          end else if (!start_r && (run_rem_r == '0)) begin
            res_status_nxt = nfs_pkg::ST_BOUNDS;
          end else begin
            if (start_r) begin
              run_failed_nxt = 1'b0;
            end
            if ({1'b0, idx} >= CAP_C[nfs_pkg::LEN_W-1:0]) begin
              res_status_nxt = nfs_pkg::ST_BOUNDS;
              run_cur_nxt    = idx + 1'b1;
              run_rem_nxt    = base_rem - 1'b1;
            end else if ((func_r == nfs_pkg::FN_PROGRAM) && !start_r && run_failed_r) begin
              res_status_nxt = nfs_pkg::ST_RUN_FAILED;
              run_cur_nxt    = idx + 1'b1;
              run_rem_nxt    = base_rem - 1'b1;
            end else begin
              // store read issued this cycle; the data step advances the run
              run_cur_nxt = idx;
              run_rem_nxt = base_rem;
              state_nxt   = nfs_pkg::S_DATA;
            end
          end
        end
      end

      nfs_pkg::S_DATA: begin
        run_cur_nxt = acc_addr_r + 1'b1;
        run_rem_nxt = run_rem_r - 1'b1;
        state_nxt   = nfs_pkg::S_FIN;
        if (func_r == nfs_pkg::FN_READ) begin
          res_rd_nxt = mem_q_r;
        end else if ((~mem_q_r & data_r) != 8'h00) begin
          res_status_nxt = nfs_pkg::ST_SET_BIT;
          run_failed_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = acc_addr_r[AW-1:0];
          mem_wdata = mem_q_r & data_r;
        end
      end

      // sector index by reciprocal multiply; may come out one low
      nfs_pkg::S_DIV: begin
        q_nxt     = q_prod[PROD_W-1:nfs_pkg::ADDR_W];
        state_nxt = nfs_pkg::S_BASE;
      end

      nfs_pkg::S_BASE: begin
        cur_nxt   = base_est;
        state_nxt = nfs_pkg::S_SETUP;
      end

      // bump the estimate one sector if the address lies past it
      nfs_pkg::S_SETUP: begin
        if (sec_off >= SEC_C) begin
          cur_nxt = cur_r + SEC_C;
        end
        end_nxt   = (func_r == nfs_pkg::FN_ERASE_SEC) ? (addr_w + 1'b1) : range_end;
        state_nxt = nfs_pkg::S_SECCHK;
      end

      nfs_pkg::S_SECCHK: begin
        if (cur_r >= end_r) begin
          state_nxt = nfs_pkg::S_FIN;
        end else if (!sec_fits) begin
          res_status_nxt = nfs_pkg::ST_BOUNDS;
          state_nxt      = nfs_pkg::S_FIN;
        end else begin
          waddr_nxt = cur_r[AW-1:0];
          off_nxt   = '0;
          state_nxt = nfs_pkg::S_ERASE;
        end
      end

      nfs_pkg::S_ERASE: begin
        mem_we    = 1'b1;
        waddr_nxt = waddr_r + 1'b1;
        off_nxt   = off_r + 1'b1;
        if (off_r == SEC_LAST) begin
          cur_nxt   = cur_r + SEC_C;
          state_nxt = nfs_pkg::S_SECCHK;
        end
      end

      nfs_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rd_nxt     = res_rd_r;
          state_nxt      = nfs_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = nfs_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nfs_pkg::S_CLEAR;
      ready_r      <= 1'b0;
      run_cur_r    <= '0;
      run_rem_r    <= '0;
      run_failed_r <= 1'b0;
      waddr_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        ready_r <= cfg_wdata;
      end
      run_cur_r    <= run_cur_nxt;
      run_rem_r    <= run_rem_nxt;
      run_failed_r <= run_failed_nxt;
      waddr_r      <= waddr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    start_r      <= start_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    data_r       <= data_nxt;
    acc_addr_r   <= acc_addr_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    q_r          <= q_nxt;
    cur_r        <= cur_nxt;
    end_r        <= end_nxt;
    off_r        <= off_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[mem_raddr];
  end

`ifndef ASSERT_OFF
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == nfs_pkg::S_CHECK))
    else $error("accepted word did not enter check");

  a_erase_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfs_pkg::S_ERASE) |-> ((cur_r + SEC_C) <= CAP_C))
    else $error("erase walk beyond store");

  a_run_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (run_rem_r != '0) |-> (({2'b00, run_cur_r} + {1'b0, run_rem_r}) <= CAP_C))
    else $error("active run reaches past store end");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfs_pkg::S_CLEAR) |-> !out_valid_r)
    else $error("result presented during clearing sweep");

  a_program_fail_marks_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == nfs_pkg::S_DATA) && (func_r == nfs_pkg::FN_PROGRAM) &&
     ((~mem_q_r & data_r) != 8'h00)) |=> (run_failed_r &&
     (res_status_r == nfs_pkg::ST_SET_BIT)))
    else $error("failed program did not mark run");
`endif

endmodule

// File: sim/tb_nor_flash_store_model.sv
`timescale 1ns / 1ps
// Self-checking bench for nor_flash_store_model: a queue-fed driver, a shadow flash store
// that predicts every reply, and a monitor that compares replies in order.
// Depends on nfs_pkg and the nor_flash_store_model RTL.
module tb_nor_flash_store_model;

  localparam int FLASH_BYTES = 65536;
  localparam int SECTOR_LEN  = 4096;

  typedef struct packed {
    logic [1:0]                 func;
    logic                       run_start;
    logic [nfs_pkg::ADDR_W-1:0] address;
    logic [nfs_pkg::LEN_W-1:0]  run_length;
    logic [7:0]                 data_byte;
  } flash_op_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic [7:0] read_data;
  } flash_reply_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic                       cfg_wdata = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_func = '0;
  logic                       in_run_start = 1'b0;
  logic [nfs_pkg::ADDR_W-1:0] in_address = '0;
  logic [nfs_pkg::LEN_W-1:0]  in_run_length = '0;
  logic [7:0]                 in_data_byte = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_ok;
  logic [2:0]                 out_status;
  logic [7:0]                 out_read_data;

  // shadow copy of the flash and its run state
  logic [7:0]                 shadow_mem [FLASH_BYTES];
  logic [nfs_pkg::ADDR_W-1:0] shadow_cursor = '0;
  logic [nfs_pkg::LEN_W-1:0]  shadow_left = '0;
  bit                         shadow_failed = 1'b0;
  bit                         shadow_ready = 1'b0;

  flash_op_t    flash_ops_queued [$];
  flash_reply_t flash_replies_due [$];
  flash_op_t    cur_op;

  int  error_count = 0;
  int  words_accepted = 0;
  int  replies_seen = 0;
  int  sectors_wiped = 0;
  int  cfg_writes = 0;
  int  status_tally [8];
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;

  nor_flash_store_model #(
    .CAPACITY_BYTES(FLASH_BYTES),
    .SECTOR_BYTES  (SECTOR_LEN)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_run_start (in_run_start),
    .in_address   (in_address),
    .in_run_length(in_run_length),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_status   (out_status),
    .out_read_data(out_read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit span_fits(input longint unsigned start, input longint unsigned len);
    if (len == 0) return 1'b1;
    if (start >= FLASH_BYTES) return 1'b0;
    return (start + len) <= FLASH_BYTES;
  endfunction

  function automatic bit wipe_sector(input longint unsigned addr);
    longint unsigned base;
    base = addr - (addr % SECTOR_LEN);
    if (!span_fits(base, SECTOR_LEN)) return 1'b0;
    for (int i = 0; i < SECTOR_LEN; i++) shadow_mem[base + i] = nfs_pkg::FILL_BYTE;
    sectors_wiped++;
    return 1'b1;
  endfunction

  // Applies one word to the shadow flash and returns the reply the block owes.
  function automatic flash_reply_t emulate_flash_op(input flash_op_t op);
    flash_reply_t    rep;
    logic [2:0]      st;
    logic [7:0]      rd;
    logic [7:0]      old;
    longint unsigned cur;
    longint unsigned stop;
    bit              go;
    st = nfs_pkg::ST_OK;
    rd = 8'h00;
    go = 1'b1;
    if (!shadow_ready) begin
      st = nfs_pkg::ST_NOT_READY;
    end else if (op.func == nfs_pkg::FN_ERASE_SEC) begin
      if (!wipe_sector(op.address)) st = nfs_pkg::ST_BOUNDS;
    end else if (op.func == nfs_pkg::FN_ERASE_RANGE) begin
      if (!span_fits(op.address, op.run_length)) begin
        st = nfs_pkg::ST_BOUNDS;
      end else if (op.run_length != 0) begin
        cur = op.address - (op.address % SECTOR_LEN);
        stop = op.address + op.run_length;
        while (cur < stop) begin
          if (!wipe_sector(cur)) begin
            st = nfs_pkg::ST_BOUNDS;
            break;
          end
          cur += SECTOR_LEN;
        end
      end
    end else begin
      if (op.run_start) begin
        shadow_left = '0;
        shadow_failed = 1'b0;
        if (!span_fits(op.address, op.run_length)) begin
          st = nfs_pkg::ST_BOUNDS;
          go = 1'b0;
        end else if (op.run_length == 0) begin
          go = 1'b0;
        end else begin
          shadow_cursor = op.address;
          shadow_left = op.run_length;
        end
      end else if (shadow_left == 0) begin
        st = nfs_pkg::ST_BOUNDS;
        go = 1'b0;
      end
      if (go) begin
        if (shadow_cursor >= FLASH_BYTES) begin
          st = nfs_pkg::ST_BOUNDS;
        end else if (op.func == nfs_pkg::FN_READ) begin
          rd = shadow_mem[shadow_cursor];
        end else if (shadow_failed) begin
          st = nfs_pkg::ST_RUN_FAILED;
        end else begin
          old = shadow_mem[shadow_cursor];
          if ((~old & op.data_byte) != 8'h00) begin
            st = nfs_pkg::ST_SET_BIT;
            shadow_failed = 1'b1;
          end else begin
            shadow_mem[shadow_cursor] = old & op.data_byte;
          end
        end
        shadow_cursor = shadow_cursor + 1'b1;  // wraps at address width
        shadow_left = shadow_left - 1'b1;
      end
    end
    rep.ok = (st == nfs_pkg::ST_OK);
    rep.status = st;
    rep.read_data = rd;
    return rep;
  endfunction

  // mostly no idle, some short gaps, now and then a long one
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // addresses clustered at the store start, a sector boundary and the store end
  function automatic logic [nfs_pkg::ADDR_W-1:0] pick_spot();
    int unsigned spot;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: spot = $urandom_range(0, 63);
      4, 5, 6:    spot = SECTOR_LEN - 32 + $urandom_range(0, 63);
      7, 8:       spot = FLASH_BYTES - 48 + $urandom_range(0, 47);
      default:    spot = $urandom_range(0, FLASH_BYTES - 1);
    endcase
    return nfs_pkg::ADDR_W'(spot);
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom & $urandom & $urandom);  // sparse ones usually program
      4:          return 8'h00;
      5:          return nfs_pkg::FILL_BYTE;
      default:    return 8'($urandom);
    endcase
  endfunction

  task automatic queue_op(input logic [1:0] f, input logic s, input logic [nfs_pkg::ADDR_W-1:0] a,
                          input logic [nfs_pkg::LEN_W-1:0] l, input logic [7:0] d);
    flash_op_t op;
    op.func = f;
    op.run_start = s;
    op.address = a;
    op.run_length = l;
    op.data_byte = d;
    flash_ops_queued.push_back(op);
  endtask

  // Mostly complete read/program runs with random content, plus erases, strays and noise.
  task automatic queue_traffic(input int count);
    int         made;
    int         r;
    int         span;
    int         spot;
    logic [1:0] fn;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      fn = $urandom_range(0, 1) ? nfs_pkg::FN_PROGRAM : nfs_pkg::FN_READ;
      if (r < 62) begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        queue_op(fn, 1'b1, pick_spot(), nfs_pkg::LEN_W'(span), pick_data());
        made++;
        for (int i = 1; i < span; i++) begin
          if ($urandom_range(0, 19) == 0) break;  // abandon the run part way
          if ($urandom_range(0, 99) == 0)
            queue_op(nfs_pkg::FN_ERASE_SEC, 1'($urandom), pick_spot(),
                     nfs_pkg::LEN_W'($urandom), 8'($urandom));
          else
            queue_op(($urandom_range(0, 4) == 0) ? (fn ^ 2'd1) : fn, 1'b0,
                     nfs_pkg::ADDR_W'($urandom), nfs_pkg::LEN_W'($urandom), pick_data());
          made++;
        end
      end else begin
        if (r < 67) begin
          queue_op(nfs_pkg::FN_ERASE_SEC, 1'($urandom), pick_spot(),
                   nfs_pkg::LEN_W'($urandom), 8'($urandom));
        end else if (r < 70) begin
          if ($urandom_range(0, 7) == 0) begin
            spot = $urandom_range(0, SECTOR_LEN);
            queue_op(nfs_pkg::FN_ERASE_RANGE, 1'($urandom), nfs_pkg::ADDR_W'(spot),
                     nfs_pkg::LEN_W'($urandom_range(1, FLASH_BYTES - spot)), 8'($urandom));
          end else begin
            queue_op(nfs_pkg::FN_ERASE_RANGE, 1'($urandom), pick_spot(),
                     nfs_pkg::LEN_W'($urandom_range(1, 2 * SECTOR_LEN)), 8'($urandom));
          end
        end else if (r < 77) begin
          queue_op(fn, 1'b0, nfs_pkg::ADDR_W'($urandom), nfs_pkg::LEN_W'($urandom),
                   pick_data());
        end else if (r < 82) begin
          queue_op(fn, 1'b1, nfs_pkg::ADDR_W'($urandom), '0, pick_data());
        end else begin
          queue_op(2'($urandom), 1'($urandom), nfs_pkg::ADDR_W'($urandom),
                   nfs_pkg::LEN_W'($urandom), 8'($urandom));
        end
        made++;
      end
    end
  endtask

  task automatic set_ready(input bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_ready = v;
    cfg_writes++;
  endtask

  task automatic drain();
    while (flash_ops_queued.size() != 0 || in_valid || flash_replies_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic present_op(input flash_op_t op);
    cur_op = op;
    in_func <= op.func;
    in_run_start <= op.run_start;
    in_address <= op.address;
    in_run_length <= op.run_length;
    in_data_byte <= op.data_byte;
    in_valid <= 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (in_valid && !in_stall) begin
      flash_replies_due.push_back(emulate_flash_op(cur_op));
      words_accepted++;
      if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      gap_left = idle_len(in_calm);
      if (gap_left == 0 && flash_ops_queued.size() != 0)
        present_op(flash_ops_queued.pop_front());
      else
        in_valid <= 1'b0;
    end else if (!in_valid) begin
      if (gap_left != 0)
        gap_left--;
      else if (flash_ops_queued.size() != 0)
        present_op(flash_ops_queued.pop_front());
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin : reply_check
    flash_reply_t want;
    bit           stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (flash_replies_due.size() == 0) begin
          $error("reply %0d arrived with nothing expected", replies_seen);
          error_count++;
        end else begin
          want = flash_replies_due.pop_front();
          status_tally[want.status]++;
          if (out_ok !== want.ok) begin
            $error("reply %0d ok mismatch: expected %0d, got %0d", replies_seen, want.ok, out_ok);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("reply %0d status mismatch: expected %0d, got %0d", replies_seen,
                   want.status, out_status);
            error_count++;
          end
          if (out_read_data !== want.read_data) begin
            $error("reply %0d read_data mismatch: expected 0x%02h, got 0x%02h", replies_seen,
                   want.read_data, out_read_data);
            error_count++;
          end
        end
        // long hold-off so the block backs up and stalls its input
        if (replies_seen == 150 || replies_seen == 800) hold_left = 400;
      end
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else begin
        stall_left = idle_len(out_calm);
        stall_next = (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
      out_stall <= stall_next;
    end
  end

  initial begin
    for (int i = 0; i < FLASH_BYTES; i++) shadow_mem[i] = nfs_pkg::FILL_BYTE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_ready(1'b0);
    queue_traffic(30);
    drain();

    set_ready(1'b1);
    queue_op(nfs_pkg::FN_READ, 1'b1, 0, 1, 8'h00);                  // erased after reset
    queue_op(nfs_pkg::FN_PROGRAM, 1'b1, 0, 3, 8'hA5);
    queue_op(nfs_pkg::FN_PROGRAM, 1'b0, '1, '1, 8'h00);             // address/length ignored
    queue_op(nfs_pkg::FN_READ, 1'b0, 0, 0, 8'h00);                  // shares program cursor
    queue_op(nfs_pkg::FN_READ, 1'b0, 0, 0, 8'h00);                  // run used up
    queue_op(nfs_pkg::FN_PROGRAM, 1'b1, 0, 5, nfs_pkg::FILL_BYTE);  // would set bits of 0xA5
    queue_op(nfs_pkg::FN_PROGRAM, 1'b0, 0, 0, 8'h00);               // rest of run rejected
    queue_op(nfs_pkg::FN_READ, 1'b0, 0, 0, 8'h00);                  // reads still go through
    queue_op(nfs_pkg::FN_PROGRAM, 1'b0, 0, 0, 8'h00);
    queue_op(nfs_pkg::FN_READ, 1'b1, 0, 2, 8'h00);                  // restart replaces run
    queue_op(nfs_pkg::FN_PROGRAM, 1'b1, '1, 0, 8'h12);              // zero length always fits
    queue_op(nfs_pkg::FN_PROGRAM, 1'b0, 0, 0, 8'h00);
    queue_op(nfs_pkg::FN_READ, 1'b1, nfs_pkg::ADDR_W'(FLASH_BYTES - 4), 4, 8'h00);  // to top
    queue_op(nfs_pkg::FN_READ, 1'b1, nfs_pkg::ADDR_W'(FLASH_BYTES - 4), 5, 8'h00);  // past top
    queue_op(nfs_pkg::FN_PROGRAM, 1'b1, '1, '1, nfs_pkg::FILL_BYTE);
    queue_op(nfs_pkg::FN_ERASE_SEC, 1'b1, 5, '1, 8'hFF);
    queue_op(nfs_pkg::FN_ERASE_SEC, 1'b0, nfs_pkg::ADDR_W'(FLASH_BYTES - 1), 0, 8'h00);
    queue_op(nfs_pkg::FN_ERASE_SEC, 1'b0, nfs_pkg::ADDR_W'(FLASH_BYTES), 0, 8'h00);
    queue_op(nfs_pkg::FN_ERASE_RANGE, 1'b0, 0, 0, 8'h00);
    queue_op(nfs_pkg::FN_ERASE_RANGE, 1'b0, '1, 25'h1000000, 8'h00);
    queue_op(nfs_pkg::FN_ERASE_RANGE, 1'b0, nfs_pkg::ADDR_W'(SECTOR_LEN - 1), 2,
             8'h00);                                                // straddles two sectors
    queue_op(nfs_pkg::FN_PROGRAM, 1'b1, 16, 2, 8'h3C);
    queue_op(nfs_pkg::FN_ERASE_SEC, 1'b0, 24'h005123, 0, 8'h00);    // erase leaves run open
    queue_op(nfs_pkg::FN_PROGRAM, 1'b0, 0, 0, 8'h0F);
    queue_op(nfs_pkg::FN_ERASE_RANGE, 1'b0, 0, nfs_pkg::LEN_W'(FLASH_BYTES),
             8'h00);                                                // whole store
    queue_op(nfs_pkg::FN_READ, 1'b1, 16, 1, 8'h00);
    queue_traffic(580);
    drain();

    set_ready(1'b0);
    queue_traffic(30);
    drain();

    set_ready(1'b1);
    queue_traffic(530);
    drain();

    repeat (40) @(posedge clk);
    $display("Covered %0d words: %0d ok, %0d not ready, %0d out of range, %0d refused bit sets,",
             words_accepted, status_tally[nfs_pkg::ST_OK], status_tally[nfs_pkg::ST_NOT_READY],
             status_tally[nfs_pkg::ST_BOUNDS], status_tally[nfs_pkg::ST_SET_BIT]);
    $display("%0d rejected in failed runs, %0d sectors erased, %0d ready settings.",
             status_tally[nfs_pkg::ST_RUN_FAILED], sectors_wiped, cfg_writes);
    if (error_count == 0 && flash_replies_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
